FILE: sv/skht_pkg.sv
// Package for the string key hash table.
// Holds the item structs, the opcode and status codes and the controller/datapath
// command and status structs. No dependencies.
package skht_pkg;

  localparam logic [1:0] OP_FIND     = 2'd0;
  localparam logic [1:0] OP_FIND_INS = 2'd1;
  localparam logic [1:0] OP_INSERT   = 2'd2;
  localparam logic [1:0] OP_ERASE    = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ERASED    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam logic [31:0] HASH_SEED = 32'd7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic       key_last;
  } skht_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] dense_index;
    logic [6:0] entries_used;
  } skht_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       byte_en;
    logic       key_clr;
    logic       mod_start;
    logic       probe_init;
    logic       probe_next;
    logic       slot_rd;
    logic       byte_init;
    logic       byte_rd;
    logic       byte_next;
    logic       copy_wr;
    logic       ins_wr;
    logic       ers_wr;
    logic       dense_from_word;
    logic       sweep_rd;
    logic       sweep_wr;
    logic       clr_wr;
    logic       res_load;
    logic [2:0] res_status;
  } skht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic too_long;
    logic mod_done;
    logic len_match;
    logic slot_empty;
    logic byte_eq;
    logic byte_last;
    logic probe_last;
    logic sweep_last;
    logic live_full;
    logic res_ok;
  } skht_sts_t;

endpackage

FILE: sv/string_key_hash_table.sv
// Top level of the string key hash table with linear probing.
// Depends on skht_pkg, skht_ctrl, skht_dp (and through it skht_ram, skht_mod).
//
//   Channel | Handshake                    | Payload
//   --------+------------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o      | in_i  : opcode, key_byte, key_last
//   out     | out_valid_o / out_stall_i    | out_o : status, dense_index, entries_used
//
// A key byte that is not the last one is taken without a stall. On the last byte the
// block stalls its input through a dispatch state and the remainder unit, which
// reduces the hash by reciprocal multiplication; each probed slot then takes a read and
// a check state through the slot memory read port, each compared or copied key byte a
// read and a check or write state, and an erase adds a renumbering sweep of a read and a
// write state per slot. After reset a clearing pass empties all slots; input stalls then.
// A waiting result does not block new bytes; only the next operation waits for it.
module string_key_hash_table #(
  parameter int MAX_ENTRIES   = 64,
  parameter int TABLE_SLOTS   = 83,
  parameter int MAX_KEY_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  skht_pkg::skht_in_t in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output skht_pkg::skht_out_t out_o
);
  import skht_pkg::*;

  skht_cmd_t cmd;
  skht_sts_t sts;

  // The controller only walks states; all counters, memories and arithmetic live
  // in the datapath, which reports back a handful of compare results.
  skht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  skht_dp #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TABLE_SLOTS(TABLE_SLOTS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk_i, .rst_ni,
    .in_i, .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_stall_i, .out_o
  );

endmodule

FILE: sv/skht_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/skht_mod.sv
// Remainder unit: 32-bit dividend modulo a constant by reciprocal multiplication,
// registering quotient, partial, remainder. No dependencies beyond its parameter.
module skht_mod #(
  parameter int DIVISOR = 83,
  parameter int SW      = $clog2(DIVISOR)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   dividend_i,
  output logic          done_o,
  output logic [SW-1:0] rem_o
);

  // The reciprocal is 2^32 / DIVISOR rounded down, so the estimated quotient is
  // at most one below the true one and a single compare and subtract finishes.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
  localparam logic [31:0] DIV1  = 32'(DIVISOR);

  logic [31:0]   x_q;
  logic [31:0]   quo_q;
  logic [31:0]   part_q;
  logic [SW-1:0] rem_q;
  logic [2:0]    stage_q;
  logic          done_q;
  logic [63:0]   prod;
  logic [31:0]   part_d;
  logic [31:0]   rem_full;

  assign prod     = {32'd0, x_q} * {32'd0, RECIP};
  assign part_d   = x_q - quo_q * DIV1;
  assign rem_full = (part_q >= DIV1) ? part_q - DIV1 : part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      quo_q   <= '0;
      part_q  <= '0;
      rem_q   <= '0;
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
      if (start_i) begin
        x_q <= dividend_i;
      end
      if (stage_q[0]) begin
        quo_q <= prod[63:32];
      end
      if (stage_q[1]) begin
        part_q <= part_d;
      end
      if (stage_q[2]) begin
        rem_q <= rem_full[SW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/skht_dp.sv
// Datapath of the string key hash table: hash, key buffer, slot memories,
// counters, remainder unit and output register. Depends on skht_pkg, skht_ram, skht_mod.
module skht_dp #(
  parameter int MAX_ENTRIES   = 64,
  parameter int TABLE_SLOTS   = 83,
  parameter int MAX_KEY_BYTES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skht_pkg::skht_in_t  in_i,
  input  skht_pkg::skht_cmd_t cmd_i,
  output skht_pkg::skht_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skht_pkg::skht_out_t out_o
);
  import skht_pkg::*;

  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LW  = $clog2(MAX_KEY_BYTES + 2);
  localparam int SW  = $clog2(TABLE_SLOTS);
  localparam int DW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int WW  = LW + DW;
  localparam int BYTES_DEPTH = TABLE_SLOTS * (2 ** KAW);

  logic [LW-1:0]  cnt_q;
  logic [31:0]    hash_q;
  logic [SW-1:0]  s_q, n_q, i_q;
  logic [KAW-1:0] idx_q;
  logic [CW-1:0]  live_q;
  logic [DW-1:0]  dense_q;
  logic           out_vld_q;
  skht_out_t      out_q;

  logic [SW-1:0]  rem;
  logic           mod_done;
  logic [7:0]     kb_rd, sb_rd;
  logic [WW-1:0]  word_rd, word_wd;
  logic [LW-1:0]  wlen;
  logic [DW-1:0]  wdense;
  logic           word_we;
  logic [SW-1:0]  word_wa;
  logic           renum;
  logic [31:0]    hash_d;

  skht_mod #(.DIVISOR(TABLE_SLOTS)) u_mod (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mod_start), .dividend_i(hash_q),
    .done_o(mod_done), .rem_o(rem)
  );

  skht_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk_i,
    .we_i(cmd_i.byte_en && (cnt_q < LW'(MAX_KEY_BYTES))),
    .waddr_i(cnt_q[KAW-1:0]), .wdata_i(in_i.key_byte),
    .re_i(cmd_i.byte_rd), .raddr_i(idx_q), .rdata_o(kb_rd)
  );

  skht_ram #(.WIDTH(8), .DEPTH(BYTES_DEPTH)) u_bytes_ram (
    .clk_i,
    .we_i(cmd_i.copy_wr), .waddr_i({s_q, idx_q}), .wdata_i(kb_rd),
    .re_i(cmd_i.byte_rd), .raddr_i({s_q, idx_q}), .rdata_o(sb_rd)
  );

  skht_ram #(.WIDTH(WW), .DEPTH(TABLE_SLOTS)) u_word_ram (
    .clk_i,
    .we_i(word_we), .waddr_i(word_wa), .wdata_i(word_wd),
    .re_i(cmd_i.slot_rd || cmd_i.sweep_rd),
    .raddr_i(cmd_i.sweep_rd ? i_q : s_q), .rdata_o(word_rd)
  );

  assign wlen   = word_rd[WW-1:DW];
  assign wdense = word_rd[DW-1:0];
  // An occupied slot above the erased dense index moves down by one.
  assign renum  = (wlen != '0) && (wdense > dense_q);

  always_comb begin
    word_we = 1'b0;
    word_wa = s_q;
    word_wd = '0;
    if (cmd_i.clr_wr) begin
      word_we = 1'b1;
      word_wa = i_q;
    end else if (cmd_i.ers_wr) begin
      word_we = 1'b1;
    end else if (cmd_i.ins_wr) begin
      word_we = 1'b1;
      word_wd = {cnt_q, DW'(live_q)};
    end else if (cmd_i.sweep_wr) begin
      word_we = renum;
      word_wa = i_q;
      word_wd = {wlen, wdense - DW'(1)};
    end
  end

  assign hash_d = (hash_q << 5) - hash_q + {{24{in_i.key_byte[7]}}, in_i.key_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      hash_q    <= HASH_SEED;
      s_q       <= '0;
      n_q       <= '0;
      i_q       <= '0;
      idx_q     <= '0;
      live_q    <= '0;
      dense_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.key_clr) begin
        cnt_q  <= '0;
        hash_q <= HASH_SEED;
      end else if (cmd_i.byte_en) begin
        hash_q <= hash_d;
        if (cnt_q <= LW'(MAX_KEY_BYTES)) begin
          cnt_q <= cnt_q + LW'(1);
        end
      end
      if (cmd_i.probe_init) begin
        s_q <= rem;
        n_q <= '0;
      end else if (cmd_i.probe_next) begin
        s_q <= (s_q == SW'(TABLE_SLOTS - 1)) ? '0 : s_q + SW'(1);
        n_q <= n_q + SW'(1);
      end
      if (cmd_i.byte_init) begin
        idx_q <= '0;
      end else if (cmd_i.byte_next) begin
        idx_q <= idx_q + KAW'(1);
      end
      if (cmd_i.clr_wr || cmd_i.sweep_wr) begin
        i_q <= (i_q == SW'(TABLE_SLOTS - 1)) ? '0 : i_q + SW'(1);
      end
      if (cmd_i.ins_wr) begin
        live_q  <= live_q + CW'(1);
        dense_q <= DW'(live_q);
      end else if (cmd_i.ers_wr) begin
        if (live_q != '0) begin
          live_q <= live_q - CW'(1);
        end
        dense_q <= wdense;
      end else if (cmd_i.dense_from_word) begin
        dense_q <= wdense;
      end
      if (cmd_i.res_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.status       <= cmd_i.res_status;
      out_q.entries_used <= 7'(live_q);
      if (cmd_i.res_status == ST_FOUND || cmd_i.res_status == ST_INSERTED ||
          cmd_i.res_status == ST_ERASED) begin
        out_q.dense_index <= 6'(dense_q);
      end else begin
        out_q.dense_index <= '0;
      end
    end
  end

  assign sts_o.too_long   = cnt_q > LW'(MAX_KEY_BYTES);
  assign sts_o.mod_done   = mod_done;
  assign sts_o.len_match  = wlen == cnt_q;
  assign sts_o.slot_empty = wlen == '0;
  assign sts_o.byte_eq    = kb_rd == sb_rd;
  assign sts_o.byte_last  = (LW'(idx_q) + LW'(1)) == cnt_q;
  assign sts_o.probe_last = n_q == SW'(TABLE_SLOTS - 1);
  assign sts_o.sweep_last = i_q == SW'(TABLE_SLOTS - 1);
  assign sts_o.live_full  = live_q >= CW'(MAX_ENTRIES);
  assign sts_o.res_ok     = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

FILE: sv/skht_ctrl.sv
// Controller of the string key hash table: sequences probe walks, key compares,
// key copies, erase renumbering and the result. Depends on skht_pkg.
module skht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  skht_pkg::skht_in_t  in_i,
  output logic                in_stall_o,
  input  skht_pkg::skht_sts_t sts_i,
  output skht_pkg::skht_cmd_t cmd_o
);
  import skht_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_MOD, S_PR_RD, S_PR_CHK, S_CMP_RD, S_CMP_CHK,
    S_INS_RD, S_INS_CHK, S_CPY_RD, S_CPY_WR, S_INS_WR, S_SW_RD, S_SW_WR, S_RES
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [2:0] st_q, st_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    op_d    = op_q;
    st_d    = st_q;
    cmd_o.res_status = st_q;

    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.byte_en = 1'b1;
          if (in_i.key_last) begin
            op_d    = in_i.opcode;
            state_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        if (sts_i.too_long) begin
          st_d    = ST_TOO_LONG;
          state_d = S_RES;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.probe_init = 1'b1;
          if (op_q == OP_INSERT) begin
            if (sts_i.live_full) begin
              st_d    = ST_FULL;
              state_d = S_RES;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            state_d = S_PR_RD;
          end
        end
      end
      S_PR_RD: begin
        cmd_o.slot_rd = 1'b1;
        state_d = S_PR_CHK;
      end
      S_PR_CHK, S_CMP_CHK: begin
        if (state_q == S_PR_CHK && sts_i.len_match) begin
          cmd_o.byte_init = 1'b1;
          state_d = S_CMP_RD;
        end else if (state_q == S_CMP_CHK && sts_i.byte_eq && !sts_i.byte_last) begin
          cmd_o.byte_next = 1'b1;
          state_d = S_CMP_RD;
        end else if (state_q == S_CMP_CHK && sts_i.byte_eq) begin
          // Whole key matches.
          if (op_q == OP_ERASE) begin
            cmd_o.ers_wr = 1'b1;
            state_d = S_SW_RD;
          end else begin
            cmd_o.dense_from_word = 1'b1;
            st_d    = ST_FOUND;
            state_d = S_RES;
          end
        end else if (!sts_i.probe_last) begin
          cmd_o.probe_next = 1'b1;
          state_d = S_PR_RD;
        end else if (op_q == OP_FIND_INS) begin
          if (sts_i.live_full) begin
            st_d    = ST_FULL;
            state_d = S_RES;
          end else begin
            cmd_o.probe_init = 1'b1;
            state_d = S_INS_RD;
          end
        end else begin
          st_d    = ST_NOT_FOUND;
          state_d = S_RES;
        end
      end
      S_CMP_RD: begin
        cmd_o.byte_rd = 1'b1;
        state_d = S_CMP_CHK;
      end
      S_INS_RD: begin
        cmd_o.slot_rd = 1'b1;
        state_d = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (sts_i.slot_empty) begin
          cmd_o.byte_init = 1'b1;
          state_d = S_CPY_RD;
        end else if (sts_i.probe_last) begin
          st_d    = ST_FULL;
          state_d = S_RES;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = S_INS_RD;
        end
      end
      S_CPY_RD: begin
        cmd_o.byte_rd = 1'b1;
        state_d = S_CPY_WR;
      end
      S_CPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        if (sts_i.byte_last) begin
          state_d = S_INS_WR;
        end else begin
          cmd_o.byte_next = 1'b1;
          state_d = S_CPY_RD;
        end
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        st_d    = ST_INSERTED;
        state_d = S_RES;
      end
      S_SW_RD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          st_d    = ST_ERASED;
          state_d = S_RES;
        end else begin
          state_d = S_SW_RD;
        end
      end
      S_RES: begin
        if (sts_i.res_ok) begin
          cmd_o.res_load = 1'b1;
          cmd_o.key_clr  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      op_q    <= OP_FIND;
      st_q    <= ST_FOUND;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

FILE: sv/skht_chk.sv
// Port-level checker for the string key hash table, bound to the top level.
// Depends on skht_pkg.
module skht_chk #(
  parameter int MAX_ENTRIES = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input skht_pkg::skht_out_t out_o
);
  import skht_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_ins_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_INSERTED |->
      out_o.dense_index == 6'(out_o.entries_used - 7'd1))
    else $error("inserted index is not the last dense index");

  a_found_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_FOUND |-> out_o.entries_used != 7'd0)
    else $error("key found in an empty table");

  a_zero_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_NOT_FOUND || out_o.status == ST_FULL ||
      out_o.status == ST_TOO_LONG) |-> out_o.dense_index == 6'd0)
    else $error("dense index given without a key");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_ENTRIES > 127) || (out_o.entries_used <= 7'(MAX_ENTRIES)))
    else $error("entry count above capacity");

endmodule

bind string_key_hash_table skht_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_skht_chk (.*);

FILE: test/tb_string_key_hash_table.sv
// Self-checking testbench for string_key_hash_table.
// Depends on skht_pkg and the block itself; a built-in predictor of the probing
// table checks every result item against the expected one, in order.
module tb_string_key_hash_table;
  import skht_pkg::*;

  localparam int NUM_SLOTS = 83;
  localparam int MAX_LIVE  = 64;
  localparam int MAX_KEY   = 128;
  localparam int ITEM_GOAL = 1050;
  localparam int CYCLE_CAP = 4000000;
  localparam int POOL_KEYS = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  skht_in_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  skht_out_t out_o;

  string_key_hash_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: the key being assembled and the table contents.
  logic [7:0]  pend_bytes [MAX_KEY];
  int          pend_len;
  logic [31:0] pend_hash;
  logic [7:0]  slot_bytes [NUM_SLOTS][MAX_KEY];
  int          slot_len [NUM_SLOTS];
  int          slot_rank [NUM_SLOTS];
  int          live_keys;

  skht_out_t   pending_results[$];
  int          items_sent;
  int          results_seen;
  int          mismatches;
  int          cycle_count;
  bit          idle_on;
  bit          filled;
  int          out_hold;

  logic [7:0]  key_scratch [MAX_KEY + 2];
  logic [7:0]  pool_bytes [POOL_KEYS][8];
  int          pool_len [POOL_KEYS];

  // Walk the probe path once from the home slot of the pending key.
  function automatic bit probe_match(output int slot);
    int s;
    bit same;
    s = int'(pend_hash % NUM_SLOTS);
    slot = 0;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      if (slot_len[s] == pend_len) begin
        same = 1'b1;
        for (int i = 0; i < pend_len; i++)
          if (slot_bytes[s][i] != pend_bytes[i]) same = 1'b0;
        if (same) begin
          slot = s;
          return 1'b1;
        end
      end
      s = (s + 1 >= NUM_SLOTS) ? 0 : s + 1;
    end
    return 1'b0;
  endfunction

  // Duplicates are allowed: the key lands in the first empty slot on its path.
  function automatic logic [2:0] place_key(output int rank);
    int s;
    s = int'(pend_hash % NUM_SLOTS);
    rank = 0;
    if (live_keys >= MAX_LIVE) return ST_FULL;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      if (slot_len[s] == 0) begin
        for (int i = 0; i < pend_len; i++) slot_bytes[s][i] = pend_bytes[i];
        slot_len[s] = pend_len;
        slot_rank[s] = live_keys;
        rank = live_keys;
        live_keys++;
        return ST_INSERTED;
      end
      s = (s + 1 >= NUM_SLOTS) ? 0 : s + 1;
    end
    return ST_FULL;
  endfunction

  // Folds one accepted byte into the pending key; on the last byte it runs the
  // operation and returns the result item.
  function automatic bit table_step(input skht_in_t it, output skht_out_t res);
    logic [2:0] st;
    int rank, s, gone;
    res = '0;
    if (pend_len < MAX_KEY) pend_bytes[pend_len] = it.key_byte;
    if (pend_len <= MAX_KEY) pend_len++;
    pend_hash = pend_hash * 32'd31 + {{24{it.key_byte[7]}}, it.key_byte};
    if (!it.key_last) return 1'b0;
    rank = 0;
    if (pend_len > MAX_KEY) begin
      st = ST_TOO_LONG;
    end else begin
      case (it.opcode)
        OP_FIND: begin
          if (probe_match(s)) begin
            st = ST_FOUND;
            rank = slot_rank[s];
          end else begin
            st = ST_NOT_FOUND;
          end
        end
        OP_FIND_INS: begin
          if (probe_match(s)) begin
            st = ST_FOUND;
            rank = slot_rank[s];
          end else begin
            st = place_key(rank);
          end
        end
        OP_INSERT: st = place_key(rank);
        default: begin
          if (!probe_match(s)) begin
            st = ST_NOT_FOUND;
          end else begin
            // Close the gap in the dense numbering left by the erased key.
            gone = slot_rank[s];
            slot_len[s] = 0;
            slot_rank[s] = 0;
            if (live_keys > 0) live_keys--;
            for (int i = 0; i < NUM_SLOTS; i++)
              if (slot_len[i] != 0 && slot_rank[i] > gone) slot_rank[i]--;
            rank = gone;
            st = ST_ERASED;
          end
        end
      endcase
    end
    res.status = st;
    res.dense_index = rank[5:0];
    res.entries_used = live_keys[6:0];
    pend_len = 0;
    pend_hash = HASH_SEED;
    return 1'b1;
  endfunction

  // Presents one item, holds it through any stall, and records the expected
  // result. A typed expectation, when given, replaces the predicted one.
  task automatic send_item(input skht_in_t it, input bit typed, input skht_out_t typed_res);
    skht_out_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (table_step(it, res)) pending_results.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sends key_scratch[0 .. len-1] as one key; the opcode only matters on the
  // last byte, so the earlier bytes carry random opcodes.
  task automatic send_key(input logic [1:0] op, input int len);
    skht_in_t it;
    for (int i = 0; i < len; i++) begin
      it.opcode = (i == len - 1) ? op : 2'($urandom_range(0, 3));
      it.key_byte = key_scratch[i];
      it.key_last = (i == len - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Receiver side: stall in short random bursts while idling is enabled.
  always @(negedge clk_i) begin
    logic hold;
    if (out_hold > 0) begin
      out_hold--;
      hold = 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 2);
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    out_stall_i <= hold;
  end

  // Result checker and run-time limit.
  always @(posedge clk_i) begin
    skht_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb_string_key_hash_table: done, errors");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: status %0d dense %0d used %0d",
                   out_o.status, out_o.dense_index, out_o.entries_used);
      end else begin
        want = pending_results.pop_front();
        if (out_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     results_seen, want.status, want.dense_index, want.entries_used,
                     out_o.status, out_o.dense_index, out_o.entries_used);
        end
      end
    end
  end

  typedef struct {
    skht_in_t  it;
    bit        typed;
    skht_out_t res;
  } directed_row_t;

  directed_row_t directed [19];

  initial begin
    int pick, len;
    logic [1:0] op;
    pend_len = 0;
    pend_hash = HASH_SEED;
    live_keys = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_len[i] = 0;
      slot_rank[i] = 0;
    end
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    out_hold = 0;
    idle_on = 1'b1;
    filled = 1'b0;

    // Single-byte keys have results that can be worked out by hand; the two-byte
    // keys check byte order in the compare and are left to the predictor. The
    // duplicate 0xFF shows that a find stops at the first copy on the probe path
    // and that erasing it renumbers the later copy.
    directed[0]  = '{'{OP_FIND,     8'h41, 1'b1}, 1, '{ST_NOT_FOUND, 6'd0, 7'd0}};
    directed[1]  = '{'{OP_INSERT,   8'h00, 1'b1}, 1, '{ST_INSERTED,  6'd0, 7'd1}};
    directed[2]  = '{'{OP_FIND,     8'h00, 1'b1}, 1, '{ST_FOUND,     6'd0, 7'd1}};
    directed[3]  = '{'{OP_FIND_INS, 8'hFF, 1'b1}, 1, '{ST_INSERTED,  6'd1, 7'd2}};
    directed[4]  = '{'{OP_INSERT,   8'hFF, 1'b1}, 1, '{ST_INSERTED,  6'd2, 7'd3}};
    directed[5]  = '{'{OP_FIND,     8'hFF, 1'b1}, 1, '{ST_FOUND,     6'd1, 7'd3}};
    directed[6]  = '{'{OP_ERASE,    8'hFF, 1'b1}, 1, '{ST_ERASED,    6'd1, 7'd2}};
    directed[7]  = '{'{OP_FIND,     8'hFF, 1'b1}, 1, '{ST_FOUND,     6'd1, 7'd2}};
    directed[8]  = '{'{OP_ERASE,    8'hFF, 1'b1}, 1, '{ST_ERASED,    6'd1, 7'd1}};
    directed[9]  = '{'{OP_ERASE,    8'hFF, 1'b1}, 1, '{ST_NOT_FOUND, 6'd0, 7'd1}};
    directed[10] = '{'{OP_ERASE,    8'h80, 1'b0}, 0, '0};
    directed[11] = '{'{OP_FIND_INS, 8'h7F, 1'b1}, 0, '0};
    directed[12] = '{'{OP_INSERT,   8'h80, 1'b0}, 0, '0};
    directed[13] = '{'{OP_FIND,     8'h7F, 1'b1}, 0, '0};
    directed[14] = '{'{OP_FIND,     8'h7F, 1'b0}, 0, '0};
    directed[15] = '{'{OP_FIND,     8'h80, 1'b1}, 0, '0};
    directed[16] = '{'{OP_ERASE,    8'h00, 1'b1}, 1, '{ST_ERASED,    6'd0, 7'd1}};
    directed[17] = '{'{OP_FIND_INS, 8'h80, 1'b0}, 0, '0};
    directed[18] = '{'{OP_FIND,     8'h7F, 1'b1}, 0, '0};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].res);

    // Longest legal key for find-or-insert and find, then one byte too many for find-or-insert.
    for (int i = 0; i < MAX_KEY + 1; i++) key_scratch[i] = 8'($urandom);
    send_key(OP_FIND_INS, MAX_KEY);
    send_key(OP_FIND, MAX_KEY);
    send_key(OP_FIND_INS, MAX_KEY + 1);

    // A pool of short keys so that random finds and erases hit live entries.
    for (int k = 0; k < POOL_KEYS; k++) begin
      pool_len[k] = $urandom_range(1, 4);
      for (int i = 0; i < 8; i++) pool_bytes[k][i] = 8'($urandom);
    end

    while (items_sent < ITEM_GOAL) begin
      if (items_sent > 600 && !filled) begin
        // Let the block drain, then fill it with one-byte keys until inserts
        // are refused for lack of room.
        filled = 1'b1;
        wait_for_results();
        while (live_keys < MAX_LIVE) begin
          key_scratch[0] = 8'($urandom);
          send_key(OP_INSERT, 1);
        end
        key_scratch[0] = 8'($urandom);
        send_key(OP_INSERT, 1);
        send_key(OP_FIND_INS, 1);
      end
      if (items_sent > ITEM_GOAL - 150) idle_on = 1'b0;
      op = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, POOL_KEYS - 1);
        len = pool_len[pick];
        for (int i = 0; i < len; i++) key_scratch[i] = pool_bytes[pick][i];
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) key_scratch[i] = 8'($urandom);
      end
      send_key(op, len);
    end

    wait_for_results();
    repeat (400) @(negedge clk_i);
    mismatches += pending_results.size();
    $display("covered %0d key bytes and %0d result items, %0d keys live at the end",
             items_sent, results_seen, live_keys);
    if (mismatches == 0) begin
      $display("tb_string_key_hash_table: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_string_key_hash_table: done, errors");
    end
    $finish;
  end

endmodule
